FILE: hdl/srpfc_pkg.sv
package srpfc_pkg;

	// Widest row the block tracks. The pivot index is six bits wide, so
	// columns at or beyond 64 are out of range whatever this is set to.
	localparam int MAX_COLS = 64;
	localparam int COL_LIMIT_INT = (MAX_COLS < 64) ? MAX_COLS : 64;
	localparam logic [6:0] COL_LIMIT = 7'(COL_LIMIT_INT);
	localparam logic [6:0] COL_COUNT_MAX = 7'd127;

	localparam int DEG_W = 17;
	localparam int SHIFT_W = 16;
	localparam int SDEG_W = 18;
	localparam int COL_W = 6;
	localparam int NUM_PIVOT_COLS = 64;

	localparam logic signed [DEG_W-1:0] DEG_NONE = '1;
	localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = 16'sh7fff;

	// Summary of the current row, including the beat being processed.
	typedef struct packed {
		logic nonzero;
		logic [COL_W-1:0] col;
		logic signed [DEG_W-1:0] deg;
		logic signed [SDEG_W-1:0] sdeg;
		logic overflow;
	} row_sum_t;

endpackage

FILE: hdl/shifted_row_pivot_form_check.sv
// Shifted weak Popov form check on a stream of polynomial matrix entries.
// The entry channel carries one matrix entry per beat in row-major order: its
// degree (negative for a zero entry), the shift of its column, and row-end and
// matrix-end marks. Columns are counted internally from zero in each row.
// The result channel carries one beat per row end with the row's pivot column,
// pivot degree, shifted row degree, zero-row flag and the running weak Popov
// and ordered weak Popov verdicts of the matrix. Feed the matrix column-major
// to test the column forms instead.
// Every entry beat passes through an input register and the row and matrix
// update is one short compare-and-select step, so one beat is taken in every
// cycle while entry_stall is low. A row-end beat goes from the input register
// to the result register. The result register sits between the two sides,
// so entries that do not end a row keep flowing while a result is held.
// When the receiver stalls with a result pending and the next registered
// entry ends another row, entry_stall rises until the result is taken.
// Reset clears all row and matrix state and empties both registers; the
// verdicts start at one and the column overflow flag at zero.
module shifted_row_pivot_form_check (
	input  logic clk,
	input  logic arst_n,
	input  logic entry_valid,
	output logic entry_stall,
	input  logic signed [16:0] entry_degree,
	input  logic signed [15:0] col_shift,
	input  logic last_in_row,
	input  logic last_in_matrix,
	output logic result_valid,
	input  logic result_stall,
	output logic [5:0] pivot_index,
	output logic zero_row,
	output logic signed [16:0] pivot_degree,
	output logic signed [17:0] shifted_row_degree,
	output logic weak_popov_ok,
	output logic ordered_ok,
	output logic matrix_end,
	output logic too_many_columns
);

	// Input register stage.
	logic valid_s1;
	logic signed [16:0] degree_s1;
	logic signed [15:0] shift_s1;
	logic row_end_s1;
	logic mat_end_s1;

	// Matrix-wide state.
	logic [srpfc_pkg::NUM_PIVOT_COLS-1:0] used_q;
	logic [5:0] prev_pivot_q;
	logic first_row_q;
	logic weak_q;
	logic ordered_q;
	logic overflow_q;

	srpfc_pkg::row_sum_t sum;
	logic row_end;
	logic step;
	logic out_free;
	logic weak_n;
	logic ordered_n;
	logic overflow_n;

	// A registered beat that ends a row needs the result register free, or
	// the current result leaving in this same cycle.
	assign row_end = row_end_s1 | mat_end_s1;
	assign out_free = !result_valid || !result_stall;
	assign step = valid_s1 && (!row_end || out_free);
	assign entry_stall = valid_s1 && !step;

	srpfc_row u_row (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.row_end(row_end),
		.entry_degree(degree_s1),
		.col_shift(shift_s1),
		.sum(sum)
	);

	always_comb begin
		overflow_n = overflow_q | sum.overflow;
		if (sum.nonzero) begin
			weak_n = weak_q && !used_q[sum.col];
			ordered_n = ordered_q && (first_row_q || sum.col > prev_pivot_q);
		end else begin
			// A zero row breaks both forms.
			weak_n = 1'b0;
			ordered_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!entry_stall) begin
			valid_s1 <= entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (entry_valid && !entry_stall) begin
			degree_s1 <= entry_degree;
			shift_s1 <= col_shift;
			row_end_s1 <= last_in_row;
			mat_end_s1 <= last_in_matrix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			prev_pivot_q <= '0;
			first_row_q <= 1'b1;
			weak_q <= 1'b1;
			ordered_q <= 1'b1;
			overflow_q <= 1'b0;
		end else if (step) begin
			if (mat_end_s1) begin
				used_q <= '0;
				prev_pivot_q <= '0;
				first_row_q <= 1'b1;
				weak_q <= 1'b1;
				ordered_q <= 1'b1;
				overflow_q <= 1'b0;
			end else if (row_end) begin
				overflow_q <= overflow_n;
				weak_q <= weak_n;
				ordered_q <= ordered_n;
				if (sum.nonzero) begin
					used_q <= used_q | (64'd1 << sum.col);
					prev_pivot_q <= sum.col;
					first_row_q <= 1'b0;
				end
			end else begin
				overflow_q <= overflow_n;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (step && row_end) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && row_end) begin
			pivot_index <= sum.col;
			zero_row <= !sum.nonzero;
			pivot_degree <= sum.deg;
			shifted_row_degree <= sum.sdeg;
			weak_popov_ok <= weak_n;
			ordered_ok <= ordered_n;
			matrix_end <= mat_end_s1;
			too_many_columns <= overflow_n;
		end
	end

endmodule

FILE: hdl/srpfc_row.sv
module srpfc_row (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic row_end,
	input  logic signed [srpfc_pkg::DEG_W-1:0] entry_degree,
	input  logic signed [srpfc_pkg::SHIFT_W-1:0] col_shift,
	output srpfc_pkg::row_sum_t sum
);

	logic [6:0] column_count_q;
	logic signed [srpfc_pkg::SDEG_W-1:0] best_sdeg_q;
	logic signed [srpfc_pkg::DEG_W-1:0] best_deg_q;
	logic [srpfc_pkg::COL_W-1:0] best_col_q;
	logic nonzero_q;
	logic signed [srpfc_pkg::SHIFT_W-1:0] low_shift_q;

	logic in_range;
	logic take;
	logic signed [srpfc_pkg::SDEG_W-1:0] sd;
	logic signed [srpfc_pkg::SDEG_W-1:0] best_sdeg_n;
	logic signed [srpfc_pkg::DEG_W-1:0] best_deg_n;
	logic [srpfc_pkg::COL_W-1:0] best_col_n;
	logic nonzero_n;
	logic signed [srpfc_pkg::SHIFT_W-1:0] low_shift_n;
	logic signed [srpfc_pkg::SDEG_W-1:0] low_shift_ext;

	always_comb begin
		in_range = column_count_q < srpfc_pkg::COL_LIMIT;
		sd = {entry_degree[srpfc_pkg::DEG_W-1], entry_degree}
			+ {{2{col_shift[srpfc_pkg::SHIFT_W-1]}}, col_shift};
		// The rightmost column of maximal shifted degree wins, hence >=.
		take = in_range && !entry_degree[srpfc_pkg::DEG_W-1]
			&& (!nonzero_q || sd >= best_sdeg_q);
		best_sdeg_n = take ? sd : best_sdeg_q;
		best_deg_n = take ? entry_degree : best_deg_q;
		best_col_n = take ? column_count_q[srpfc_pkg::COL_W-1:0] : best_col_q;
		nonzero_n = nonzero_q | take;
		low_shift_n = (in_range && col_shift < low_shift_q) ? col_shift : low_shift_q;
		low_shift_ext = {{2{low_shift_n[srpfc_pkg::SHIFT_W-1]}}, low_shift_n};

		sum.nonzero = nonzero_n;
		sum.col = nonzero_n ? best_col_n : '0;
		sum.deg = nonzero_n ? best_deg_n : srpfc_pkg::DEG_NONE;
		sum.sdeg = nonzero_n ? best_sdeg_n : low_shift_ext - 18'sd1;
		sum.overflow = !in_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			best_sdeg_q <= '0;
			best_deg_q <= srpfc_pkg::DEG_NONE;
			best_col_q <= '0;
			nonzero_q <= 1'b0;
			low_shift_q <= srpfc_pkg::SHIFT_MAX;
		end else if (step) begin
			if (row_end) begin
				column_count_q <= '0;
				best_sdeg_q <= '0;
				best_deg_q <= srpfc_pkg::DEG_NONE;
				best_col_q <= '0;
				nonzero_q <= 1'b0;
				low_shift_q <= srpfc_pkg::SHIFT_MAX;
			end else begin
				if (column_count_q != srpfc_pkg::COL_COUNT_MAX) begin
					column_count_q <= column_count_q + 7'd1;
				end
				best_sdeg_q <= best_sdeg_n;
				best_deg_q <= best_deg_n;
				best_col_q <= best_col_n;
				nonzero_q <= nonzero_n;
				low_shift_q <= low_shift_n;
			end
		end
	end

endmodule

FILE: hdl/srpfc_check.sv
module srpfc_check (
	input  logic clk,
	input  logic arst_n,
	input  logic result_valid,
	input  logic result_stall,
	input  logic [5:0] pivot_index,
	input  logic zero_row,
	input  logic signed [16:0] pivot_degree,
	input  logic weak_popov_ok,
	input  logic ordered_ok
);

	// A held result keeps its pivot index, zero-row flag and pivot degree on the port unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(pivot_index)
			&& $stable(zero_row) && $stable(pivot_degree))
		else $error("held result changed");

	a_zero_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && zero_row |-> !weak_popov_ok && !ordered_ok)
		else $error("zero row left a verdict set");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && zero_row |-> pivot_index == 6'd0 && pivot_degree == -17'sd1)
		else $error("zero row with pivot fields set");

	a_nonzero_deg: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !zero_row |-> !pivot_degree[16])
		else $error("nonzero row with negative pivot degree");

	// Strictly increasing pivots are always distinct.
	a_order_implies_weak: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ordered_ok |-> weak_popov_ok)
		else $error("ordered verdict without weak verdict");

endmodule

bind shifted_row_pivot_form_check srpfc_check u_srpfc_check (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.pivot_index(pivot_index),
	.zero_row(zero_row),
	.pivot_degree(pivot_degree),
	.weak_popov_ok(weak_popov_ok),
	.ordered_ok(ordered_ok)
);
